### sv/apoc_pkg.sv
// Shared types and constants for the adaptive prebuffer offset controller.
// No dependencies; imported by apoc_limit, the top level and the testbench.
package apoc_pkg;

	// Timing limits in ms, defaults for the top-level parameters
	localparam int unsigned MIN_TIME_DEF  = 100;
	localparam int unsigned MAX_TIME_DEF  = 2000;
	localparam int unsigned STEP_TIME_DEF = 100;

	// Resume window used when the register holds zero
	localparam logic [31:0] DEFAULT_RESUME = 32'd750;

	// Register reset values
	localparam logic        RST_ADAPTIVE  = 1'b0;
	localparam logic [31:0] RST_RESUME    = 32'd750;
	localparam logic [15:0] RST_BASE      = 16'd100;
	localparam logic [31:0] RST_RATE_WIN  = 32'd10000;
	localparam logic [7:0]  RST_THRESHOLD = 8'd3;
	localparam logic [31:0] RST_DECAY     = 32'd30000;

	// Event kinds carried in the input tuser
	typedef enum logic [1:0] {
		ACT_SAMPLE = 2'd0,
		ACT_DRAIN  = 2'd1,
		ACT_REFILL = 2'd2
	} action_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_ADAPTIVE  = 3'd0,
		REG_RESUME    = 3'd1,
		REG_BASE      = 3'd2,
		REG_RATE_WIN  = 3'd3,
		REG_THRESHOLD = 3'd4,
		REG_DECAY     = 3'd5
	} cfg_reg_t;

	// Clamp the requested base to MIN..MAX, lower bound first
	function automatic logic [15:0] clamp_base(
		input logic [15:0] base,
		input logic [15:0] min_t,
		input logic [15:0] max_t
	);
		logic [15:0] b;
		b = (base < min_t) ? min_t : base;
		b = (b > max_t) ? max_t : b;
		return b;
	endfunction

endpackage

### sv/apoc_limit.sv
// Step limit pipeline: clamped base, ceil((MAX - base) / STEP) capped at 255,
// and the limit expressed in ms. Depends on apoc_pkg.
module apoc_limit
	import apoc_pkg::*;
#(
	parameter int unsigned MIN_TIME  = MIN_TIME_DEF,
	parameter int unsigned MAX_TIME  = MAX_TIME_DEF,
	parameter int unsigned STEP_TIME = STEP_TIME_DEF,
	parameter int unsigned OTW       = 8 + $clog2(STEP_TIME + 1)
) (
	input  logic           clk,
	input  logic [15:0]    base_time,
	output logic [15:0]    clamped_base,
	output logic [7:0]     step_lim,
	output logic [OTW-1:0] lim_time
);

	// Reciprocal for an exact floor divide of a 16-bit value by STEP_TIME
	localparam int unsigned SH    = 16 + $clog2(STEP_TIME);
	localparam longint     RECIP  = ((longint'(1) << SH) + longint'(STEP_TIME) - 1)
	                                / longint'(STEP_TIME);
	localparam int unsigned RW    = 18;
	localparam int unsigned PW    = 16 + RW;
	localparam logic [RW-1:0]  RECIP_W = RW'(RECIP);
	localparam logic [15:0]    MIN16   = 16'(MIN_TIME);
	localparam logic [15:0]    MAX16   = 16'(MAX_TIME);
	localparam logic [15:0]    STEP16  = 16'(STEP_TIME);

	logic [15:0]    cb_q;
	logic [15:0]    span;
	logic [15:0]    span_m1;
	logic [PW-1:0]  prod_q;
	logic           span_nz_q;
	logic [PW-1:0]  prod_sh;
	logic [15:0]    quot;
	logic [7:0]     lim_q;
	logic [OTW-1:0] lim_time_q;

	// Stage A: clamp
	always_ff @(posedge clk) begin
		cb_q <= clamp_base(base_time, MIN16, MAX16);
	end

	// Stage B: (span - 1) times the reciprocal
	assign span    = MAX16 - cb_q;
	assign span_m1 = span - 16'd1;

	always_ff @(posedge clk) begin
		prod_q    <= PW'(span_m1) * PW'(RECIP_W);
		span_nz_q <= (span != 16'd0);
	end

	// Stage C: ceil as floor + 1, saturate at 255
	assign prod_sh = prod_q >> SH;
	assign quot    = prod_sh[15:0];

	always_ff @(posedge clk) begin
		if (!span_nz_q) begin
			lim_q <= 8'd0;
		end else if (quot >= 16'd255) begin
			lim_q <= 8'd255;
		end else begin
			lim_q <= quot[7:0] + 8'd1;
		end
	end

	// Stage D: limit in ms
	always_ff @(posedge clk) begin
		lim_time_q <= OTW'(lim_q) * OTW'(STEP16);
	end

	assign clamped_base = cb_q;
	assign step_lim     = lim_q;
	assign lim_time     = lim_time_q;

endmodule

### sv/adaptive_prebuffer_offset_ctl.sv
// Throughput one word per cycle while the result side is not stalled and no settle count is running.
// Each word passes an input register, then the state update and the result register.
// After reset and after every base_time write, s_axis_tready stays low while the settle count runs down
// and the step limit pipeline (clamp, reciprocal multiply, saturate, scale) refills.
// Reset (arst_n low, asynchronous) clears all event state, counters and the offset,
// and loads the register reset values.
// Top level of the adaptive prebuffer offset controller. Depends on apoc_pkg, apoc_limit.
module adaptive_prebuffer_offset_ctl
	import apoc_pkg::*;
#(
	parameter int unsigned MIN_TIME  = MIN_TIME_DEF,
	parameter int unsigned MAX_TIME  = MAX_TIME_DEF,
	parameter int unsigned STEP_TIME = STEP_TIME_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input events
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // [31:0] now_time, [63:32] recovery_total
	input  logic [1:0]  s_axis_tuser,  // [1:0] action
	// results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] effective_time, [23:16] offset_now, [55:24] transition_count,
	// [87:56] resume_count
	output logic [87:0] m_axis_tdata,
	output logic [0:0]  m_axis_tuser,  // [0] resumed
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int unsigned OTW    = 8 + $clog2(STEP_TIME + 1);
	localparam int unsigned SW     = ((OTW > 16) ? OTW : 16) + 1;
	localparam logic [15:0] MAX16  = 16'(MAX_TIME);
	localparam logic [OTW-1:0] STEP_OT = OTW'(STEP_TIME);
	localparam logic [2:0]  SETTLE = 3'd4;

	// configuration registers
	logic        adaptive_q;
	logic [31:0] resume_win_q;
	logic [15:0] base_q;
	logic [31:0] rate_win_q;
	logic [7:0]  threshold_q;
	logic [31:0] decay_q;
	logic [2:0]  settle_q;

	// event state
	logic           drain_pend_q;
	logic [31:0]    drain_time_q;
	logic [31:0]    resume_cnt_q;
	logic           base_valid_q;
	logic [31:0]    last_total_q;
	logic [31:0]    win_start_q;
	logic [31:0]    last_rec_q;
	logic [31:0]    win_cnt_q;
	logic [7:0]     offset_q;
	logic [OTW-1:0] off_time_q;
	logic [31:0]    trans_cnt_q;

	// input register
	logic        vld_s1;
	logic [1:0]  act_s1;
	logic [31:0] now_s1;
	logic [31:0] total_s1;

	// result register
	logic        vld_s2;
	logic        resumed_s2;
	logic [15:0] eff_s2;
	logic [7:0]  offset_s2;
	logic [31:0] trans_s2;
	logic [31:0] resume_s2;

	logic           in_acc;
	logic           adv;
	logic [15:0]    cb;
	logic [7:0]     lim;
	logic [OTW-1:0] lim_time;

	// next-state values
	logic           nx_drain_pend;
	logic [31:0]    nx_drain_time;
	logic [31:0]    nx_resume_cnt;
	logic           nx_base_valid;
	logic [31:0]    nx_last_total;
	logic [31:0]    nx_win_start;
	logic [31:0]    nx_last_rec;
	logic [31:0]    nx_win_cnt;
	logic [7:0]     nx_offset;
	logic [OTW-1:0] nx_off_time;
	logic [31:0]    nx_trans_cnt;
	logic           nx_resumed;
	logic [15:0]    nx_eff;
	logic [31:0]    delta;
	logic [31:0]    res_win;
	logic [SW-1:0]  eff_sum;

	apoc_limit #(
		.MIN_TIME  (MIN_TIME),
		.MAX_TIME  (MAX_TIME),
		.STEP_TIME (STEP_TIME),
		.OTW       (OTW)
	) u_limit (
		.clk          (clk),
		.base_time    (base_q),
		.clamped_base (cb),
		.step_lim     (lim),
		.lim_time     (lim_time)
	);

	// handshake
	assign cfg_ready     = 1'b1;
	assign adv           = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = (settle_q == 3'd0) && (!vld_s1 || adv);
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// configuration writes; a base write restarts the limit settle count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adaptive_q   <= RST_ADAPTIVE;
			resume_win_q <= RST_RESUME;
			base_q       <= RST_BASE;
			rate_win_q   <= RST_RATE_WIN;
			threshold_q  <= RST_THRESHOLD;
			decay_q      <= RST_DECAY;
			settle_q     <= SETTLE;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_ADAPTIVE:  adaptive_q   <= cfg_data[0];
					REG_RESUME:    resume_win_q <= cfg_data;
					REG_BASE:      base_q       <= cfg_data[15:0];
					REG_RATE_WIN:  rate_win_q   <= cfg_data;
					REG_THRESHOLD: threshold_q  <= cfg_data[7:0];
					REG_DECAY:     decay_q      <= cfg_data;
					default:       ;
				endcase
			end
			if (cfg_valid && cfg_ready && cfg_index == REG_BASE) begin
				settle_q <= SETTLE;
			end else if (settle_q != 3'd0) begin
				settle_q <= settle_q - 3'd1;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_s1   <= s_axis_tuser;
			now_s1   <= s_axis_tdata[31:0];
			total_s1 <= s_axis_tdata[63:32];
		end
	end

	// event processing
	always_comb begin
		nx_drain_pend = drain_pend_q;
		nx_drain_time = drain_time_q;
		nx_resume_cnt = resume_cnt_q;
		nx_base_valid = base_valid_q;
		nx_last_total = last_total_q;
		nx_win_start  = win_start_q;
		nx_last_rec   = last_rec_q;
		nx_win_cnt    = win_cnt_q;
		nx_trans_cnt  = trans_cnt_q;
		nx_resumed    = 1'b0;
		delta         = total_s1 - last_total_q;
		res_win       = (resume_win_q == 32'd0) ? DEFAULT_RESUME : resume_win_q;

		// re-cap the offset against the current base
		if (offset_q > lim) begin
			nx_offset   = lim;
			nx_off_time = lim_time;
		end else begin
			nx_offset   = offset_q;
			nx_off_time = off_time_q;
		end

		unique case (act_s1)
			ACT_SAMPLE: begin
				if (!base_valid_q) begin
					nx_base_valid = 1'b1;
					nx_last_total = total_s1;
					nx_win_start  = now_s1;
					nx_last_rec   = now_s1;
				end else begin
					nx_last_total = total_s1;
					if (adaptive_q) begin
						if (delta != 32'd0) begin
							nx_win_cnt  = nx_win_cnt + delta;
							nx_last_rec = now_s1;
						end
						if ((now_s1 - nx_win_start) >= rate_win_q) begin
							nx_win_start = now_s1;
							nx_win_cnt   = delta;
						end
						// raise
						if (nx_win_cnt >= 32'(threshold_q)) begin
							if (nx_offset < lim) begin
								nx_offset    = nx_offset + 8'd1;
								nx_off_time  = nx_off_time + STEP_OT;
								nx_trans_cnt = nx_trans_cnt + 32'd1;
							end
							nx_win_cnt   = 32'd0;
							nx_win_start = now_s1;
						end
						// decay after a quiet period
						if (nx_offset != 8'd0 && (now_s1 - nx_last_rec) >= decay_q) begin
							nx_offset    = nx_offset - 8'd1;
							nx_off_time  = nx_off_time - STEP_OT;
							nx_trans_cnt = nx_trans_cnt + 32'd1;
							nx_last_rec  = now_s1;
						end
					end
				end
			end
			ACT_DRAIN: begin
				nx_drain_pend = 1'b1;
				nx_drain_time = now_s1;
			end
			ACT_REFILL: begin
				if (drain_pend_q) begin
					nx_drain_pend = 1'b0;
					if ((now_s1 - drain_time_q) <= res_win) begin
						nx_resume_cnt = resume_cnt_q + 32'd1;
						nx_resumed    = 1'b1;
					end
				end
			end
			default: ;
		endcase

		// effective time
		eff_sum = SW'(cb) + SW'(nx_off_time);
		if (!adaptive_q) begin
			nx_eff = base_q;
		end else if (eff_sum > SW'(MAX16)) begin
			nx_eff = MAX16;
		end else begin
			nx_eff = eff_sum[15:0];
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_pend_q <= 1'b0;
			drain_time_q <= '0;
			resume_cnt_q <= '0;
			base_valid_q <= 1'b0;
			last_total_q <= '0;
			win_start_q  <= '0;
			last_rec_q   <= '0;
			win_cnt_q    <= '0;
			offset_q     <= '0;
			off_time_q   <= '0;
			trans_cnt_q  <= '0;
		end else if (adv) begin
			drain_pend_q <= nx_drain_pend;
			drain_time_q <= nx_drain_time;
			resume_cnt_q <= nx_resume_cnt;
			base_valid_q <= nx_base_valid;
			last_total_q <= nx_last_total;
			win_start_q  <= nx_win_start;
			last_rec_q   <= nx_last_rec;
			win_cnt_q    <= nx_win_cnt;
			offset_q     <= nx_offset;
			off_time_q   <= nx_off_time;
			trans_cnt_q  <= nx_trans_cnt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			resumed_s2 <= nx_resumed;
			eff_s2     <= nx_eff;
			offset_s2  <= nx_offset;
			trans_s2   <= nx_trans_cnt;
			resume_s2  <= nx_resume_cnt;
		end
	end

	assign m_axis_tvalid   = vld_s2;
	assign m_axis_tuser[0] = resumed_s2;
	assign m_axis_tdata    = {resume_s2, trans_s2, offset_s2, eff_s2};

endmodule

### sv/apoc_checker.sv
// Port-level checks for adaptive_prebuffer_offset_ctl, attached by bind.
// Depends on the top level's port list only.
module apoc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [87:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	logic        have_prev_q;
	logic [31:0] prev_trans_q;
	logic [31:0] prev_resume_q;
	logic        out_acc;

	assign out_acc = m_axis_tvalid && m_axis_tready;

	// counters of the last delivered word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q   <= 1'b0;
			prev_trans_q  <= '0;
			prev_resume_q <= '0;
		end else if (out_acc) begin
			have_prev_q   <= 1'b1;
			prev_trans_q  <= m_axis_tdata[55:24];
			prev_resume_q <= m_axis_tdata[87:56];
		end
	end

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("result word changed while stalled");

	// resume count steps exactly with the resumed flag
	a_resume: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && have_prev_q |->
		m_axis_tdata[87:56] == prev_resume_q + 32'(m_axis_tuser[0]))
		else $error("resume count does not follow resumed flag");

	// at most one raise and one decay per event
	a_trans: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && have_prev_q |-> (m_axis_tdata[55:24] - prev_trans_q) <= 32'd2)
		else $error("transition count jumped by more than two");

	// no result in the cycle after reset is seen
	a_reset: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("result valid during reset");

endmodule

bind adaptive_prebuffer_offset_ctl apoc_checker u_apoc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

### tb/sv/tb.sv
// Self-checking testbench for adaptive_prebuffer_offset_ctl: directed and random
// events, random stalls on both streams. Depends on apoc_pkg and the block's RTL.
module tb;
	import apoc_pkg::*;

	// Reserved event kind: passes through with no state change but the offset re-cap
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// One result word, first declared field in the highest bits
	typedef struct packed {
		logic [31:0] resumes;
		logic [31:0] transitions;
		logic [7:0]  offset;
		logic [15:0] eff_time;
		logic        resumed;
	} result_t;

	// Holds its own copy of the registers and event state and predicts each result word
	class prebuffer_predictor;
		logic        adaptive;
		logic [31:0] resume_win;
		logic [15:0] base_ms;
		logic [31:0] rate_win;
		logic [7:0]  thresh;
		logic [31:0] quiet_ms;

		logic        drain_armed;
		logic [31:0] drain_at;
		logic [31:0] resumes;
		logic        baseline_seen;
		logic [31:0] prev_total;
		logic [31:0] win_start;
		logic [31:0] last_rec_at;
		logic [31:0] win_count;
		logic [7:0]  offset;
		logic [31:0] transitions;

		result_t due_results[$];
		int      mismatches;

		function new();
			adaptive      = RST_ADAPTIVE;
			resume_win    = RST_RESUME;
			base_ms       = RST_BASE;
			rate_win      = RST_RATE_WIN;
			thresh        = RST_THRESHOLD;
			quiet_ms      = RST_DECAY;
			drain_armed   = 1'b0;
			drain_at      = '0;
			resumes       = '0;
			baseline_seen = 1'b0;
			prev_total    = '0;
			win_start     = '0;
			last_rec_at   = '0;
			win_count     = '0;
			offset        = '0;
			transitions   = '0;
			mismatches    = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [31:0] val);
			case (idx)
				REG_ADAPTIVE:  adaptive   = val[0];
				REG_RESUME:    resume_win = val;
				REG_BASE:      base_ms    = val[15:0];
				REG_RATE_WIN:  rate_win   = val;
				REG_THRESHOLD: thresh     = val[7:0];
				REG_DECAY:     quiet_ms   = val;
				default: ;
			endcase
		endfunction

		// Base raised to MIN first, then lowered to MAX
		function int unsigned clamped_base();
			int unsigned b;
			b = base_ms;
			if (b < MIN_TIME_DEF) b = MIN_TIME_DEF;
			if (b > MAX_TIME_DEF) b = MAX_TIME_DEF;
			return b;
		endfunction

		// Steps up to MAX, rounded up, saturated at the offset width
		function int unsigned step_cap();
			int unsigned span, s;
			span = MAX_TIME_DEF - clamped_base();
			s = (span + STEP_TIME_DEF - 1) / STEP_TIME_DEF;
			return (s > 255) ? 255 : s;
		endfunction

		// Recovery sample: baseline, window counting, raise and quiet decay
		function void count_recoveries(logic [31:0] total, logic [31:0] now);
			logic [31:0] delta, elapsed;
			if (!baseline_seen) begin
				baseline_seen = 1'b1;
				prev_total    = total;
				win_start     = now;
				last_rec_at   = now;
				return;
			end
			delta = total - prev_total;
			prev_total = total;
			if (!adaptive) return;
			if (delta != 0) begin
				win_count   = win_count + delta;
				last_rec_at = now;
			end
			elapsed = now - win_start;
			if (elapsed >= rate_win) begin
				win_start = now;
				win_count = delta;
			end
			if (win_count >= {24'd0, thresh}) begin
				if (offset < step_cap()) begin
					offset      = offset + 1'b1;
					transitions = transitions + 1;
				end
				win_count = '0;
				win_start = now;
			end
			elapsed = now - last_rec_at;
			if (offset != 0 && elapsed >= quiet_ms) begin
				offset      = offset - 1'b1;
				transitions = transitions + 1;
				last_rec_at = now;
			end
		endfunction

		// Accepted input word: advance state and queue the expected result
		function void note_event(logic [1:0] act, logic [31:0] now, logic [31:0] total);
			result_t     r;
			int unsigned cap, eff;
			logic [31:0] win, gap;
			cap = step_cap();
			if (offset > cap) offset = cap[7:0];
			r.resumed = 1'b0;
			case (act)
				ACT_SAMPLE: count_recoveries(total, now);
				ACT_DRAIN: begin
					drain_armed = 1'b1;
					drain_at    = now;
				end
				ACT_REFILL: begin
					if (drain_armed) begin
						win = (resume_win != 0) ? resume_win : DEFAULT_RESUME;
						drain_armed = 1'b0;
						gap = now - drain_at;
						if (gap <= win) begin
							resumes   = resumes + 1;
							r.resumed = 1'b1;
						end
					end
				end
				default: ;
			endcase
			if (!adaptive) begin
				eff = base_ms;
			end else begin
				eff = clamped_base() + offset * STEP_TIME_DEF;
				if (eff > MAX_TIME_DEF) eff = MAX_TIME_DEF;
			end
			r.eff_time    = eff[15:0];
			r.offset      = offset;
			r.transitions = transitions;
			r.resumes     = resumes;
			due_results.push_back(r);
		endfunction

		// Accepted output word against the oldest expectation
		function void check_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				$error("result word with nothing expected: %h", got);
				mismatches++;
				return;
			end
			want = due_results.pop_front();
			if (got.resumed !== want.resumed) begin
				$error("resumed: expected %0d, actual %0d", want.resumed, got.resumed);
				mismatches++;
			end
			if (got.eff_time !== want.eff_time) begin
				$error("effective_time: expected %0d, actual %0d", want.eff_time, got.eff_time);
				mismatches++;
			end
			if (got.offset !== want.offset) begin
				$error("offset_now: expected %0d, actual %0d", want.offset, got.offset);
				mismatches++;
			end
			if (got.transitions !== want.transitions) begin
				$error("transition_count: expected %0d, actual %0d",
					want.transitions, got.transitions);
				mismatches++;
			end
			if (got.resumes !== want.resumes) begin
				$error("resume_count: expected %0d, actual %0d", want.resumes, got.resumes);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;   // [31:0] now_time, [63:32] recovery_total
	logic [1:0]  s_axis_tuser = '0;   // [1:0] action
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// [15:0] effective_time, [23:16] offset_now, [55:24] transition_count,
	// [87:56] resume_count
	logic [87:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;       // [0] resumed
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	prebuffer_predictor board;
	logic [31:0] clock_ms;
	logic [31:0] recov_total;
	int          src_calm = 0;
	int          sink_calm = 0;

	always #10 clk = ~clk;

	adaptive_prebuffer_offset_ctl i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Idle cycles before the next word; runs of zero gaps now and then
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 10);
	endfunction

	// Offer one event word and wait for it to be taken; valid stays high afterwards
	task automatic send_event(input logic [1:0] act, input logic [31:0] now,
		input logic [31:0] total);
		int gap;
		gap = draw_gap(src_calm);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {total, now};
		s_axis_tuser  <= act;
		do @(posedge clk); while (!s_axis_tready);
		board.note_event(act, now, total);
	endtask

	// Let the block drain, then idle before returning
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (board.due_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, val);
	endtask

	task automatic configure(input logic adapt, input logic [31:0] resume_ms,
		input logic [15:0] base, input logic [31:0] rate_ms, input logic [7:0] thr,
		input logic [31:0] quiet);
		wait_idle();
		write_reg(REG_ADAPTIVE, {31'd0, adapt});
		write_reg(REG_RESUME, resume_ms);
		write_reg(REG_BASE, {16'd0, base});
		write_reg(REG_RATE_WIN, rate_ms);
		write_reg(REG_THRESHOLD, {24'd0, thr});
		write_reg(REG_DECAY, quiet);
		cfg_valid <= 1'b0;
	endtask

	// Random events: clock mostly creeps forward, sometimes jumps; totals mostly grow slowly
	task automatic run_random(input int count, input int step_max);
		int          r;
		logic [1:0]  act;
		logic [31:0] total;
		repeat (count) begin
			r = $urandom_range(0, 99);
			if (r < 4)
				clock_ms = $urandom;
			else if (r < 10)
				clock_ms = clock_ms + $urandom_range(step_max, 8 * step_max);
			else
				clock_ms = clock_ms + $urandom_range(0, step_max);
			r = $urandom_range(0, 99);
			total = $urandom;
			if (r < 55) begin
				act = ACT_SAMPLE;
				r = $urandom_range(0, 19);
				if (r == 0)
					recov_total = $urandom;
				else if (r < 15)
					recov_total = recov_total + $urandom_range(0, 2);
				else
					recov_total = recov_total + $urandom_range(3, 12);
				total = recov_total;
			end else if (r < 73) begin
				act = ACT_DRAIN;
			end else if (r < 95) begin
				act = ACT_REFILL;
			end else begin
				act = ACT_UNUSED;
			end
			send_event(act, clock_ms, total);
		end
	endtask

	// Result side: random stalls, check every word taken
	initial begin
		int gap;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = draw_gap(sink_calm);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			board.check_result({m_axis_tdata, m_axis_tuser});
		end
	end

	// Stimulus and end of run
	initial begin
		board = new();
		clock_ms = '0;
		recov_total = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, pass-through mode: baseline, field extremes, resume cases
		send_event(ACT_SAMPLE, 32'd0, 32'd0);
		send_event(ACT_SAMPLE, 32'd10, 32'd5);
		send_event(ACT_REFILL, 32'd20, 32'hFFFF_FFFF);          // refill with no drain
		send_event(ACT_DRAIN, 32'd100, 32'd0);
		send_event(ACT_REFILL, 32'd850, 32'd0);                 // right at the window edge
		send_event(ACT_DRAIN, 32'd900, 32'd0);
		send_event(ACT_REFILL, 32'd1651, 32'd0);                // one ms late
		send_event(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_event(ACT_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_event(ACT_DRAIN, 32'hFFFF_FF00, 32'd0);
		send_event(ACT_REFILL, 32'h0000_0100, 32'd0);           // time wraps between them

		// Zero window and threshold, base below MIN, default resume window
		configure(1'b1, 32'd0, 16'd0, 32'd0, 8'd0, 32'd1);
		send_event(ACT_SAMPLE, 32'd2000, 32'd7);                // total wraps past zero
		send_event(ACT_SAMPLE, 32'd2001, 32'd7);
		send_event(ACT_SAMPLE, 32'd2001, 32'd9);
		send_event(ACT_DRAIN, 32'd2100, 32'd0);
		send_event(ACT_REFILL, 32'd2850, 32'd0);
		send_event(ACT_DRAIN, 32'd3000, 32'd0);
		send_event(ACT_REFILL, 32'd3751, 32'd0);
		send_event(ACT_UNUSED, 32'd3800, 32'd0);

		// Base at MAX: offset is cut back to zero on the next word
		configure(1'b1, 32'd0, 16'd2000, 32'd0, 8'd0, 32'd1);
		send_event(ACT_SAMPLE, 32'd4000, 32'd9);
		send_event(ACT_REFILL, 32'd4001, 32'd0);

		clock_ms = 32'd5000;
		recov_total = 32'd9;

		configure(1'b1, 32'd300, 16'd100, 32'd200, 8'd1, 32'd1000);
		run_random(120, 120);
		configure(1'b1, 32'd750, 16'd1500, 32'd500, 8'd2, 32'd3000);
		run_random(100, 300);
		configure(1'b1, 32'd0, 16'hFFFF, 32'd1, 8'd255, 32'hFFFF_FFFF);
		run_random(80, 500);
		configure(1'b1, 32'hFFFF_FFFF, 16'd1950, 32'd1000, 8'd3, 32'd2000);
		run_random(100, 400);
		configure(1'b0, 32'd1, 16'd2000, 32'hFFFF_FFFF, 8'd1, 32'd100);
		run_random(100, 3);
		configure(1'b1, 32'd750, 16'd100, 32'd10000, 8'd3, 32'd30000);
		run_random(150, 3000);
		configure(1'b1, 32'd500, 16'd0, 32'd0, 8'd0, 32'd50);
		run_random(100, 60);
		configure(1'b1, 32'd1000, 16'd800, 32'd2000, 8'd4, 32'd5000);
		run_random(100, 800);

		wait_idle();
		repeat (10) @(posedge clk);
		if (board.mismatches == 0 && board.due_results.size() == 0) begin
			$display("** adaptive_prebuffer_offset_ctl: PASSED **");
		end else begin
			$display("** adaptive_prebuffer_offset_ctl: FAILED **");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#8000000;
		$display("** adaptive_prebuffer_offset_ctl: FAILED **");
		$finish;
	end

endmodule
